@@ sv/tpt_pkg.sv @@
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared types and constants of the tunnel peer table.
// ----------------------------------------------------------------------------
package tpt_pkg;

	localparam int TableEntries = 256;
	localparam int IdxW = $clog2(TableEntries);

	// register indexes
	localparam logic [1:0] REG_POOL_BASE = 2'd0;
	localparam logic [1:0] REG_POOL_SIZE = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;

	localparam logic [31:0] PoolBaseRst = 32'd167772162;
	localparam logic [8:0] PoolSizeRst = 9'd252;
	localparam logic [31:0] TimeoutRst = 32'd300;
	localparam logic [8:0] FreedMax = 9'd511;

	typedef enum logic [1:0] {
		MODE_LEARN = 2'd0,
		MODE_LOOKUP = 2'd1,
		MODE_TICK = 2'd2,
		MODE_SWEEP = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_KNOWN = 3'd0,
		ST_NEW = 3'd1,
		ST_FULL = 3'd2,
		ST_FOUND = 3'd3,
		ST_MISS = 3'd4,
		ST_TICK = 3'd5,
		ST_SWEPT = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH,
		S_LOOKUP,
		S_DONE
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic scan_step;
		logic learn_wr;
		logic lookup_rd;
		logic result_ld;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic scan_last;
		logic out_free;
		mode_t mode;
	} dp_sts_t;

endpackage

@@ sv/tunnel_peer_table_top.sv @@
// ----------------------------------------------------------------------------
// tunnel_peer_table_top
// Peer to tunnel address binding table with idle aging.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries mode, peer_addr, peer_port and
//   query_addr. Output channel (out_valid/out_ready) returns one result per
//   transfer: status, tunnel_addr, found_addr, found_port, freed_count.
//   Configuration: cfg_we/cfg_index/cfg_data, write only while idle.
// Steps per item (input transfer to result register):
//   learn  one 256-slot scan, pipeline drain, table write
//   sweep  same scan over the slot memories
//   lookup one registered memory read
//   tick   result loads directly, seconds counter advances
//   The scan visits one slot a cycle through the single read port of the
//   slot memories; items are worked one at a time.
// Hand-off: the next item is taken the cycle after the result loads.
// Reset: all slots free, seconds counter zero, registers to defaults.
// Stall: a finished result waits in the output register; the next item is
//   taken meanwhile and its result waits until the register empties.
// ----------------------------------------------------------------------------
module tunnel_peer_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [31:0] peer_addr,
	input  logic [15:0] peer_port,
	input  logic [31:0] query_addr,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] tunnel_addr,
	output logic [31:0] found_addr,
	output logic [15:0] found_port,
	output logic [8:0]  freed_count
);
	import tpt_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	state_t state;

	// controller
	tpt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_mode(mode),
		.in_ready(in_ready), .sts(sts), .cmd(cmd), .state(state)
	);

	// datapath
	tpt_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_mode(mode), .in_paddr(peer_addr),
		.in_pport(peer_port), .in_qaddr(query_addr), .cmd(cmd), .sts(sts),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.tunnel_addr(tunnel_addr), .found_addr(found_addr),
		.found_port(found_port), .freed_count(freed_count)
	);

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("item accepted while busy");

	// freed count only on sweep results
	a_freed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && freed_count != 9'd0) |-> (status == ST_SWEPT))
		else $error("freed count on non-sweep result");

	// tunnel address only on known or new learn results
	a_taddr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && tunnel_addr != 32'd0) |-> (status == ST_KNOWN || status == ST_NEW))
		else $error("tunnel address on wrong status");

	// result load never overwrites an untaken result
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(state == S_DONE && out_valid && !out_ready) |=> (state == S_DONE))
		else $error("result dropped");

endmodule

@@ sv/tpt_ctrl.sv @@
// ----------------------------------------------------------------------------
// tpt_ctrl
// Controller: sequences table scans, lookups and result hand-off.
// ----------------------------------------------------------------------------
module tpt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        in_mode,
	output logic              in_ready,
	input  tpt_pkg::dp_sts_t  sts,
	output tpt_pkg::dp_cmd_t  cmd,
	output tpt_pkg::state_t   state
);
	import tpt_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (mode_t'(in_mode))
						MODE_LEARN, MODE_SWEEP: state_d = S_SCAN;
						MODE_LOOKUP: state_d = S_LOOKUP;
						MODE_TICK: state_d = S_DONE;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_SCAN: if (sts.scan_last) state_d = S_DRAIN;
			S_DRAIN: state_d = S_FINISH;
			S_FINISH: state_d = S_DONE;
			S_LOOKUP: state_d = S_DONE;
			S_DONE: if (sts.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
			end
			S_SCAN: cmd.scan_step = 1'b1;
			S_FINISH: cmd.learn_wr = (sts.mode == MODE_LEARN);
			S_LOOKUP: cmd.lookup_rd = 1'b1;
			S_DONE: cmd.result_ld = sts.out_free;
			default: ;
		endcase
	end

	assign state = state_q;

endmodule

@@ sv/tpt_dp.sv @@
// ----------------------------------------------------------------------------
// tpt_dp
// Datapath: config registers, slot memories, scan pipeline, output register.
// ----------------------------------------------------------------------------
module tpt_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic [1:0]        in_mode,
	input  logic [31:0]       in_paddr,
	input  logic [15:0]       in_pport,
	input  logic [31:0]       in_qaddr,
	input  tpt_pkg::dp_cmd_t  cmd,
	output tpt_pkg::dp_sts_t  sts,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        status,
	output logic [31:0]       tunnel_addr,
	output logic [31:0]       found_addr,
	output logic [15:0]       found_port,
	output logic [8:0]        freed_count
);
	import tpt_pkg::*;

	logic [31:0] pool_base_q, timeout_q, now_q;
	logic [8:0] pool_size_q;
	logic [TableEntries-1:0] used_q;

	logic [31:0] mem_addr [TableEntries];
	logic [15:0] mem_port [TableEntries];
	logic [31:0] mem_seen [TableEntries];

	mode_t mode_q;
	logic [31:0] paddr_q, qaddr_q;
	logic [15:0] pport_q;
	logic [IdxW-1:0] idx_q, idx_s1, hit_slot_q, free_slot_q;
	logic vld_s1, hit_q, got_q, lk_hit_q;
	logic [31:0] rd_addr_s1, rd_seen_s1;
	logic [15:0] rd_port_s1;
	logic [8:0] freed_q;
	logic [31:0] off;
	logic [IdxW-1:0] rd_idx;

	assign off = qaddr_q - pool_base_q;
	assign rd_idx = cmd.lookup_rd ? off[IdxW-1:0] : idx_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= PoolBaseRst;
			pool_size_q <= PoolSizeRst;
			timeout_q <= TimeoutRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POOL_BASE: pool_base_q <= cfg_data;
				REG_POOL_SIZE: pool_size_q <= cfg_data[8:0];
				REG_TIMEOUT: timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// captured item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode_t'(in_mode);
			paddr_q <= in_paddr;
			pport_q <= in_pport;
			qaddr_q <= in_qaddr;
		end
	end

	// slot memories, registered read held while a lookup result waits
	always_ff @(posedge clk) begin
		if (cmd.scan_step || cmd.lookup_rd) begin
			rd_addr_s1 <= mem_addr[rd_idx];
			rd_port_s1 <= mem_port[rd_idx];
			rd_seen_s1 <= mem_seen[rd_idx];
		end
		if (cmd.learn_wr && !hit_q && got_q) begin
			mem_addr[free_slot_q] <= paddr_q;
			mem_port[free_slot_q] <= pport_q;
		end
		if (cmd.learn_wr && !hit_q && got_q) begin
			mem_seen[free_slot_q] <= now_q;
		end else if (vld_s1 && mode_q == MODE_LEARN && used_q[idx_s1]
				&& rd_addr_s1 == paddr_q) begin
			mem_seen[idx_s1] <= now_q;
		end
	end

	// scan pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			vld_s1 <= 1'b0;
			idx_s1 <= '0;
		end else begin
			vld_s1 <= cmd.scan_step;
			idx_s1 <= idx_q;
			if (cmd.capture) idx_q <= '0;
			else if (cmd.scan_step) idx_q <= idx_q + 1'b1;
		end
	end

	// scan evaluation, slot valid bits and seconds counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			now_q <= '0;
			hit_q <= 1'b0;
			got_q <= 1'b0;
			lk_hit_q <= 1'b0;
			freed_q <= '0;
			hit_slot_q <= '0;
			free_slot_q <= '0;
		end else begin
			if (cmd.capture) begin
				hit_q <= 1'b0;
				got_q <= 1'b0;
				freed_q <= '0;
			end
			if (vld_s1 && mode_q == MODE_LEARN) begin
				if (used_q[idx_s1] && rd_addr_s1 == paddr_q && rd_port_s1 == pport_q
						&& !hit_q) begin
					hit_q <= 1'b1;
					hit_slot_q <= idx_s1;
				end
				if (!used_q[idx_s1] && {1'b0, idx_s1} < pool_size_q && !got_q) begin
					got_q <= 1'b1;
					free_slot_q <= idx_s1;
				end
			end
			if (vld_s1 && mode_q == MODE_SWEEP && used_q[idx_s1]
					&& (now_q - rd_seen_s1) > timeout_q) begin
				used_q[idx_s1] <= 1'b0;
				if (freed_q != FreedMax) freed_q <= freed_q + 1'b1;
			end
			if (cmd.learn_wr && !hit_q && got_q) used_q[free_slot_q] <= 1'b1;
			if (cmd.lookup_rd)
				lk_hit_q <= (off[31:IdxW] == '0) && used_q[off[IdxW-1:0]];
			if (cmd.result_ld && mode_q == MODE_TICK) now_q <= now_q + 32'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.result_ld) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.result_ld) begin
			tunnel_addr <= '0;
			found_addr <= '0;
			found_port <= '0;
			freed_count <= '0;
			case (mode_q)
				MODE_LEARN: begin
					if (hit_q) begin
						status <= ST_KNOWN;
						tunnel_addr <= pool_base_q + {{(32-IdxW){1'b0}}, hit_slot_q};
					end else if (got_q) begin
						status <= ST_NEW;
						tunnel_addr <= pool_base_q + {{(32-IdxW){1'b0}}, free_slot_q};
					end else begin
						status <= ST_FULL;
					end
				end
				MODE_LOOKUP: begin
					if (lk_hit_q) begin
						status <= ST_FOUND;
						found_addr <= rd_addr_s1;
						found_port <= rd_port_s1;
					end else begin
						status <= ST_MISS;
					end
				end
				MODE_TICK: status <= ST_TICK;
				default: begin
					status <= ST_SWEPT;
					freed_count <= freed_q;
				end
			endcase
		end
	end

	assign sts.scan_last = (idx_q == {IdxW{1'b1}});
	assign sts.out_free = !out_valid || out_ready;
	assign sts.mode = mode_q;

endmodule
